[src/lldqd_pkg.sv]
// Shared types and constants for the least-load dual queue dispatch unit.
package lldqd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int COST_BITS   = 16;
    localparam int TAG_W       = 8;
    localparam int MASK_W      = 8;
    localparam int DEV_W       = 3;
    localparam int KIND_W      = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LOAD_W      = COST_BITS + PTR_W;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ERR_NONE    = 2'd0,
        ERR_NO_KIND = 2'd1,
        ERR_FULL    = 2'd2
    } err_t;

    localparam logic [KIND_W-1:0] KIND_CPU = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_GPU = KIND_W'(1);

    localparam logic QSEL_CPU = 1'b0;
    localparam logic QSEL_GPU = 1'b1;

    typedef struct packed
    {
        logic [TAG_W-1:0]     tag;
        logic [COST_BITS-1:0] cost_cpu;
        logic [COST_BITS-1:0] cost_gpu;
        logic [MASK_W-1:0]    mask;
    } entry_t;

endpackage

[src/least_load_dual_queue_dispatch_unit.sv]
// Least-load dispatch over a CPU task queue and a GPU task queue.
// Takes one word per clock while in_stall is low and returns one result word per
// word, in order. A word is captured in the input register and its result in
// the result register, which offers it on out_valid and holds it while out_stall
// is high. Each queue keeps its own head pointer, fill count and running load
// sum, so a push needs one add-and-compare and a pop one saturating subtract.
// Queue entries are not reset; only filled entries are ever read.
module least_load_dual_queue_dispatch_unit
    import lldqd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [TAG_W-1:0]     task_tag,
    input  logic [COST_BITS-1:0] cost_on_cpu,
    input  logic [COST_BITS-1:0] cost_on_gpu,
    input  logic                 runs_on_cpu,
    input  logic                 runs_on_gpu,
    input  logic [MASK_W-1:0]    allowed_devices,
    input  logic [KIND_W-1:0]    device_kind,
    input  logic [DEV_W-1:0]     device_number,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 placed_queue,
    output logic                 push_accepted,
    output logic [1:0]           error_code,
    output logic                 task_valid,
    output logic [TAG_W-1:0]     out_task_tag,
    output logic [COST_BITS-1:0] out_cost_on_cpu,
    output logic [COST_BITS-1:0] out_cost_on_gpu,
    output logic [MASK_W-1:0]    out_allowed_devices,
    output logic                 has_work
);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // input register
    logic              in_vld_reg;
    op_t               op_reg;
    entry_t            in_entry_reg;
    logic              on_cpu_reg;
    logic              on_gpu_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [DEV_W-1:0]  dev_reg;

    // queue state, index 0 CPU, 1 GPU
    entry_t            q_reg     [2][QUEUE_DEPTH];
    logic [PTR_W-1:0]  head_reg  [2];
    logic [PTR_W-1:0]  head_next [2];
    logic [CNT_W-1:0]  count_reg [2];
    logic [CNT_W-1:0]  count_next[2];
    logic [LOAD_W-1:0] load_reg  [2];
    logic [LOAD_W-1:0] load_next [2];

    // result register
    logic              out_vld_reg;
    logic              placed_reg,   placed_next;
    logic              accepted_reg, accepted_next;
    err_t              err_reg,      err_next;
    logic              tvalid_reg,   tvalid_next;
    entry_t            got_reg,      got_next;
    logic              work_reg,     work_next;

    logic              advance;
    logic              process;
    logic              wr_en;
    logic              wr_side;
    logic [PTR_W-1:0]  wr_ptr;
    logic              side;
    logic [LOAD_W:0]   tot_cpu;
    logic [LOAD_W:0]   tot_gpu;
    logic              to_gpu;
    logic [COST_BITS-1:0] side_cost;
    logic [LOAD_W-1:0] cost_ext;
    entry_t            head_e;

    assign advance  = !out_vld_reg || !out_stall;
    assign process  = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            op_reg       <= op_t'(operation);
            in_entry_reg <= '{tag: task_tag, cost_cpu: cost_on_cpu,
                               cost_gpu: cost_on_gpu, mask: allowed_devices};
            on_cpu_reg   <= runs_on_cpu;
            on_gpu_reg   <= runs_on_gpu;
            kind_reg     <= device_kind;
            dev_reg      <= device_number;
        end
    end

    // least-load choice for a task that runs on both kinds
    assign tot_cpu = (LOAD_W + 1)'(in_entry_reg.cost_cpu) + (LOAD_W + 1)'(load_reg[QSEL_CPU]);
    assign tot_gpu = (LOAD_W + 1)'(in_entry_reg.cost_gpu) + (LOAD_W + 1)'(load_reg[QSEL_GPU]);

    always_comb
    begin
        if (on_cpu_reg && on_gpu_reg)
        begin
            to_gpu = !(tot_cpu < tot_gpu);
        end
        else
        begin
            to_gpu = on_gpu_reg;
        end
    end

    assign side = (op_reg == OP_PUSH) ? to_gpu : kind_reg[0];
    assign head_e = q_reg[side][head_reg[side]];
    assign side_cost = (side == QSEL_GPU) ? ((op_reg == OP_PUSH) ? in_entry_reg.cost_gpu
                                                                 : head_e.cost_gpu)
                                          : ((op_reg == OP_PUSH) ? in_entry_reg.cost_cpu
                                                                 : head_e.cost_cpu);
    assign cost_ext = LOAD_W'(side_cost);

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            head_next[s]  = head_reg[s];
            count_next[s] = count_reg[s];
            load_next[s]  = load_reg[s];
        end
        wr_en         = 1'b0;
        wr_side       = side;
        wr_ptr        = head_reg[side] + count_reg[side][PTR_W-1:0];
        placed_next   = 1'b0;
        accepted_next = 1'b0;
        err_next      = ERR_NONE;
        tvalid_next   = 1'b0;
        got_next      = '0;

        if (process)
        begin
            if (op_reg == OP_PUSH)
            begin
                if (!on_cpu_reg && !on_gpu_reg)
                begin
                    err_next = ERR_NO_KIND;
                end
                else
                begin
                    placed_next = side;
                    if (count_reg[side] == CNT_FULL)
                    begin
                        err_next = ERR_FULL;
                    end
                    else
                    begin
                        wr_en             = 1'b1;
                        accepted_next     = 1'b1;
                        count_next[side]  = count_reg[side] + CNT_W'(1);
                        load_next[side]   = load_reg[side] + cost_ext;
                    end
                end
            end
            else if ((kind_reg == KIND_CPU || kind_reg == KIND_GPU)
                     && count_reg[side] != '0 && head_e.mask[dev_reg])
            begin
                tvalid_next      = 1'b1;
                got_next         = head_e;
                head_next[side]  = head_reg[side] + PTR_W'(1);
                count_next[side] = count_reg[side] - CNT_W'(1);
                load_next[side]  = (load_reg[side] >= cost_ext) ? load_reg[side] - cost_ext
                                                                : '0;
            end
        end

        work_next = (count_next[QSEL_CPU] != '0) || (count_next[QSEL_GPU] != '0);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_side][wr_ptr] <= in_entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 2; s++)
            begin
                head_reg[s]  <= '0;
                count_reg[s] <= '0;
                load_reg[s]  <= '0;
            end
            out_vld_reg <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < 2; s++)
            begin
                head_reg[s]  <= head_next[s];
                count_reg[s] <= count_next[s];
                load_reg[s]  <= load_next[s];
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            placed_reg   <= placed_next;
            accepted_reg <= accepted_next;
            err_reg      <= err_next;
            tvalid_reg   <= tvalid_next;
            got_reg      <= got_next;
            work_reg     <= work_next;
        end
    end

    assign out_valid           = out_vld_reg;
    assign placed_queue        = placed_reg;
    assign push_accepted       = accepted_reg;
    assign error_code          = err_reg;
    assign task_valid          = tvalid_reg;
    assign out_task_tag        = got_reg.tag;
    assign out_cost_on_cpu     = got_reg.cost_cpu;
    assign out_cost_on_gpu     = got_reg.cost_gpu;
    assign out_allowed_devices = got_reg.mask;
    assign has_work            = work_reg;

endmodule
